@@ hdl/mbps_pkg.sv @@
// Shared types and constants for the masked byte pattern search block.
// Register indexes, field widths and the decoded configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned PATTERN_BYTES  = 16;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned MATCH_OFFSET_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_MASK_LOW       = 3'd3,
    REG_MASK_HIGH      = 3'd4
  } cfg_idx_e;

  // byte j of pattern and mask sits in bits 8j+7 to 8j
  typedef struct packed {
    logic [LEN_W-1:0]             pattern_length;
    logic [8*PATTERN_BYTES-1:0]   pattern;
    logic [8*PATTERN_BYTES-1:0]   mask;
  } cfg_regs_t;

endpackage

`default_nettype wire

@@ hdl/mbps_if.sv @@
// Valid/ready channel interfaces: byte input, search result, register write.
// Depends on mbps_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [mbps_pkg::MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface mbps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbps_pkg::CFG_INDEX_W-1:0] index;
  logic [mbps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/mbps_cfg_regs.sv @@
// Configuration register file: pattern length, pattern bytes and masks.
// Depends on mbps_pkg and the mbps_cfg_if interface.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  mbps_cfg_if.sink            cfg_ch,
  output mbps_pkg::cfg_regs_t regs_o
);
  import mbps_pkg::*;

  cfg_regs_t regs_q;
  cfg_regs_t regs_d;
  logic      cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    regs_d = regs_q;
    if (cfg_fire) begin
      case (cfg_idx_e'(cfg_ch.index))
        REG_PATTERN_LENGTH: regs_d.pattern_length = cfg_ch.data[LEN_W-1:0];
        REG_PATTERN_LOW:    regs_d.pattern[CFG_DATA_W-1:0] = cfg_ch.data;
        REG_PATTERN_HIGH:   regs_d.pattern[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_ch.data;
        REG_MASK_LOW:       regs_d.mask[CFG_DATA_W-1:0] = cfg_ch.data;
        REG_MASK_HIGH:      regs_d.mask[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_ch.data;
        default:            regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

@@ hdl/mbps_match.sv @@
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg for the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module mbps_match #(
  parameter int unsigned MAX_PATTERN  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  wire [7:0]              win_i [MAX_PATTERN],
  input  wire [OFFSET_WIDTH-1:0] seen_i,
  input  mbps_pkg::cfg_regs_t    regs_i,
  output logic                   hit_o
);
  import mbps_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [LEN_W-1:0]       len;
  logic                   len_ok;
  logic [MAX_PATTERN-1:0] lane_ok;

  assign len    = regs_i.pattern_length;
  assign len_ok = (len != '0) && (len <= LEN_W'(MAX_PATTERN))
                  && (seen_i >= OFFSET_WIDTH'(len));

  // pattern byte j lines up with the byte taken len-1-j steps ago
  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [7:0]       d;
    logic [7:0]       m;
    logic [7:0]       p;
    for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
      idx = len - LEN_W'(j) - LEN_W'(1);
      d   = win_i[idx[IDX_W-1:0]];
      m   = regs_i.mask[8*j +: 8];
      p   = regs_i.pattern[8*j +: 8];
      lane_ok[j] = (LEN_W'(j) >= len) || ((d & m) == (p & m));
    end
  end

  assign hit_o = len_ok & (&lane_ok);

endmodule

`default_nettype wire

@@ hdl/masked_byte_pattern_search.sv @@
// Masked byte pattern search: one byte accepted per cycle, one result per region.
// A result is registered on the clock edge that accepts the byte that causes it.
// Throughput is one byte per cycle while no result is stalled, set by the combinational parallel window compare.
// Input is held off only while a result waits in the output register.
// Reset clears the configuration registers, the byte count, the match flag and the output valid.
// Depends on mbps_pkg, mbps_if, mbps_cfg_regs and mbps_match.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mbps_in_if.sink     in_ch,
  mbps_out_if.source  out_ch,
  mbps_cfg_if.sink    cfg_ch
);
  import mbps_pkg::*;

  cfg_regs_t                   regs;
  logic [7:0]                  win_q [MAX_PATTERN];
  logic [7:0]                  win_d [MAX_PATTERN];
  logic [OFFSET_WIDTH-1:0]     seen_q;
  logic [OFFSET_WIDTH-1:0]     seen_inc;
  logic                        done_q;
  logic                        match_hit;
  logic                        in_fire;
  logic                        out_valid_q;
  logic                        found_q;
  logic [MATCH_OFFSET_W-1:0]   offset_q;
  logic [OFFSET_WIDTH-1:0]     offset_raw;

  mbps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .regs_o (regs)
  );

  // window as it stands once the incoming byte is shifted in
  always_comb begin
    win_d[0] = in_ch.data_byte;
    for (int unsigned k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // count saturates at all ones
  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + OFFSET_WIDTH'(1);

  mbps_match #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_match (
    .win_i  (win_d),
    .seen_i (seen_inc),
    .regs_i (regs),
    .hit_o  (match_hit)
  );

  assign offset_raw  = seen_inc - OFFSET_WIDTH'(regs.pattern_length);

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // window bytes are only read once the count covers them, so no clear needed
  always_ff @(posedge clk_i) begin
    if (in_fire && !done_q) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      done_q <= 1'b0;
    end else if (in_fire) begin
      if (in_ch.last_byte) begin
        seen_q <= '0;
        done_q <= 1'b0;
      end else if (!done_q) begin
        seen_q <= seen_inc;
        done_q <= match_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && !done_q && (match_hit || in_ch.last_byte)) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !done_q && (match_hit || in_ch.last_byte)) begin
      found_q  <= match_hit;
      offset_q <= match_hit ? MATCH_OFFSET_W'(offset_raw) : '0;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.found        = found_q;
  assign out_ch.match_offset = offset_q;

  // a waiting result is never overwritten by a new byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && out_valid_q && !out_ch.ready))
    else $error("byte accepted while result stalled");

  // end of region returns the count and match flag to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_ch.last_byte |=> (seen_q == '0) && !done_q)
    else $error("region state not cleared at last byte");

  // a match before the last byte silences the rest of the region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !done_q && match_hit && !in_ch.last_byte |=> done_q && out_valid_q && found_q)
    else $error("match not recorded");

  // a not-found result always carries offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> offset_q == '0)
    else $error("not-found result with nonzero offset");

endmodule

`default_nettype wire

@@ sim/masked_byte_pattern_search_tb.sv @@
// Testbench for masked_byte_pattern_search: directed and random byte regions
// checked against an in-bench predictor of the masked window compare.
// Depends on mbps_pkg, mbps_if and the block itself.
`timescale 1ns / 1ps

module masked_byte_pattern_search_tb;
  import mbps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 4;
  localparam int FINAL_WAIT   = 20;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } search_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mbps_in_if  in_ch ();
  mbps_out_if out_ch ();
  mbps_cfg_if cfg_ch ();

  masked_byte_pattern_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  cfg_regs_t             shadow_cfg;
  logic [7:0]            shadow_window [PATTERN_BYTES];
  logic [MATCH_OFFSET_W-1:0] shadow_count;
  bit                    shadow_matched;
  search_result_t        search_results_q [$];

  int err_count;
  int cycle_count;
  bit idle_on;
  int rx_stall_left;
  int rx_hold_left;

  task automatic report_mismatch(input string what);
    if (err_count < 50) $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void clear_region();
    for (int k = 0; k < PATTERN_BYTES; k++) shadow_window[k] = 8'h00;
    shadow_count   = '0;
    shadow_matched = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    int             len;
    bit             hit;
    logic [7:0]     m, p, d;
    search_result_t r;
    len = shadow_cfg.pattern_length;
    // bytes after a match are swallowed until the region ends
    if (shadow_matched) begin
      if (last) clear_region();
      return;
    end
    for (int k = PATTERN_BYTES - 1; k > 0; k--) shadow_window[k] = shadow_window[k-1];
    shadow_window[0] = b;
    if (shadow_count != '1) shadow_count++;
    hit = 1'b0;
    if (len != 0 && len <= PATTERN_BYTES && shadow_count >= len) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        m = shadow_cfg.mask[8*j +: 8];
        p = shadow_cfg.pattern[8*j +: 8];
        d = shadow_window[len-1-j];
        if ((d & m) != (p & m)) hit = 1'b0;
      end
    end
    if (hit) begin
      r.found        = 1'b1;
      r.match_offset = shadow_count - MATCH_OFFSET_W'(len);
      search_results_q.push_back(r);
      if (last) clear_region();
      else shadow_matched = 1'b1;
    end else if (last) begin
      r.found        = 1'b0;
      r.match_offset = '0;
      search_results_q.push_back(r);
      clear_region();
    end
  endfunction

  function automatic logic [127:0] rand_bits128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // every transaction is seen here, in order: prediction first, then the check
  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.last_byte);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PATTERN_LENGTH: shadow_cfg.pattern_length = cfg_ch.data[LEN_W-1:0];
          REG_PATTERN_LOW:    shadow_cfg.pattern[63:0]   = cfg_ch.data;
          REG_PATTERN_HIGH:   shadow_cfg.pattern[127:64] = cfg_ch.data;
          REG_MASK_LOW:       shadow_cfg.mask[63:0]      = cfg_ch.data;
          REG_MASK_HIGH:      shadow_cfg.mask[127:64]    = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (search_results_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = search_results_q.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch($sformatf("found %b, wanted %b", out_ch.found, want.found));
          if (out_ch.match_offset !== want.match_offset)
            report_mismatch($sformatf("match_offset %0d, wanted %0d",
                                      out_ch.match_offset, want.match_offset));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall bursts plus an optional long hold-off
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      rx_stall_left = $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop offering bytes and wait until every expected result is out
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (search_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_pattern(input logic [LEN_W-1:0] len, input logic [127:0] pat,
                              input logic [127:0] msk);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_MASK_LOW, msk[63:0]);
    write_reg(REG_MASK_HIGH, msk[127:64]);
  endtask

  // reset registers: length zero, so the region ends not-found
  task automatic test_zero_length();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // match mid-region, then the tail bytes give nothing
  task automatic test_match_and_tail();
    load_pattern(5'd2, 128'h4241, 128'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_match_on_last();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  task automatic test_short_region();
    send_byte(8'h41, 1'b1);
  endtask

  // lengths above the window never match, whatever the mask
  task automatic test_oversized_length();
    write_reg(REG_MASK_LOW, '0);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(5'd31));
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  task automatic test_single_byte_match();
    load_pattern(5'd1, 128'hFF, 128'hFF);
    send_byte(8'hFF, 1'b1);
  endtask

  // new pattern takes effect on the byte after the write
  task automatic test_mid_region_write();
    load_pattern(5'd1, 128'h55, 128'hFF);
    send_byte(8'h00, 1'b0);
    write_reg(REG_PATTERN_LOW, '0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_all_dont_care();
    load_pattern(5'd3, rand_bits128(), '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // receiver holds off while two-byte regions keep producing results
  task automatic test_pressure();
    load_pattern(5'd1, rand_bits128(), '0);
    rx_hold_left = 300;
    for (int n = 0; n < 30; n++) begin
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic test_random_regions(input int n_items);
    int         sent, rlen, len, pos, n_regions, pick, k;
    logic [7:0] region_buf [64];
    logic [7:0] m;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick == 1) len = $urandom_range(17, 31);
      else if (pick <= 4) len = PATTERN_BYTES;
      else len = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
      end else begin
        case ($urandom_range(0, 3))
          0:       load_pattern(LEN_W'(len), rand_bits128(), '1);
          1:       load_pattern(LEN_W'(len), rand_bits128(), '0);
          2:       load_pattern(LEN_W'(len), rand_bits128(), rand_bits128());
          default: load_pattern(LEN_W'(len), rand_bits128(), rand_bits128() & rand_bits128());
        endcase
      end
      n_regions = $urandom_range(3, 8);
      for (int r = 0; r < n_regions; r++) begin
        rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        if (len == PATTERN_BYTES && $urandom_range(0, 1) == 1) rlen = $urandom_range(16, 40);
        for (int i = 0; i < rlen; i++) region_buf[i] = 8'($urandom);
        // plant a copy of the pattern, with random bits where the mask is clear
        if (len >= 1 && len <= PATTERN_BYTES && rlen >= len && $urandom_range(0, 9) < 7) begin
          pos = $urandom_range(0, rlen - len);
          for (int j = 0; j < len; j++) begin
            m = shadow_cfg.mask[8*j +: 8];
            region_buf[pos+j] = (shadow_cfg.pattern[8*j +: 8] & m) | (region_buf[pos+j] & ~m);
          end
          if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, len - 1);
            region_buf[pos+k] = region_buf[pos+k] ^ shadow_cfg.mask[8*k +: 8];
          end
        end
        for (int i = 0; i < rlen; i++) send_byte(region_buf[i], i == rlen - 1);
        sent += rlen;
        if (sent >= n_items * 4 / 5) idle_on = 1'b0;
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.last_byte  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_PATTERN_LENGTH;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    idle_on          = 1'b1;
    rx_stall_left    = 0;
    rx_hold_left     = 0;
    err_count        = 0;
    cycle_count      = 0;
    shadow_cfg       = '0;
    clear_region();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_length();
    test_match_and_tail();
    test_match_on_last();
    test_short_region();
    test_oversized_length();
    test_single_byte_match();
    test_mid_region_write();
    test_all_dont_care();
    test_pressure();
    test_random_regions(RANDOM_ITEMS);

    settle();
    repeat (FINAL_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
